[rtl/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// KMP substring search package
// Shared constants, command and result types, and status codes.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int unsigned MaxPattern  = 64;
  localparam int unsigned TextPosBits = 16;
  localparam int unsigned SymW        = 8;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned MatchPosW   = 16;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [StatusW-1:0] {
    ST_TAKEN    = 3'd0,
    ST_NOMATCH  = 3'd1,
    ST_MATCH    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_ERROR    = 3'd5
  } status_e;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEXT_CMP,
    S_BUILD_LOOP,
    S_BUILD_FIN
  } eng_state_e;

  typedef struct packed {
    op_e             op;
    logic [SymW-1:0] symbol;
    logic            last;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [MatchPosW-1:0] match_position;
  } res_t;

endpackage

[rtl/kmp_fifo.sv]
// ----------------------------------------------------------------------------
// KMP small queue
// Register-based first-in first-out queue used on both sides of the engine.
// ----------------------------------------------------------------------------
module kmp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/kmp_front.sv]
// ----------------------------------------------------------------------------
// KMP front end
// Accepts input bytes, tags them as pattern or text commands and queues them.
// ----------------------------------------------------------------------------
module kmp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        op_i,
  input  logic [kmp_pkg::SymW-1:0]    symbol_i,
  input  logic                        last_i,
  output logic                        cmd_valid_o,
  output kmp_pkg::cmd_t               cmd_o,
  input  logic                        cmd_pop_i
);

  import kmp_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_head;
  logic                q_empty;

  always_comb begin
    cmd_in.op     = op_i ? OP_TEXT : OP_PATTERN;
    cmd_in.symbol = symbol_i;
    cmd_in.last   = last_i;
  end

  kmp_fifo #(
    .Width($bits(cmd_t)),
    .Depth(QueueDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .empty_o(q_empty),
    .data_o (cmd_head),
    .pop_i  (cmd_pop_i)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_head;

endmodule

[rtl/kmp_engine.sv]
// ----------------------------------------------------------------------------
// KMP engine
// Holds the pattern and fallback memories, builds the fallback table and
// walks the text, with at most one memory read per cycle.
// ----------------------------------------------------------------------------
module kmp_engine #(
  parameter int unsigned MaxPattern  = kmp_pkg::MaxPattern,
  parameter int unsigned TextPosBits = kmp_pkg::TextPosBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  kmp_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_push_o,
  output kmp_pkg::res_t res_o,
  input  logic          res_full_i
);

  import kmp_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPattern);
  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned TiW  = TextPosBits + 1;
  localparam int unsigned PosW = (TextPosBits > MatchPosW) ? TextPosBits : MatchPosW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPattern);

  // Fallback entries are kept offset by one, so zero stands for restart.
  logic [SymW-1:0] pat_mem [MaxPattern];
  logic [LenW-1:0] fb_mem  [MaxPattern];
  logic [SymW-1:0] pat_rd_q;
  logic [LenW-1:0] fb_rd_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            pat_we;
  logic [IdxW-1:0] pat_waddr;
  logic            fb_we;
  logic [IdxW-1:0] fb_waddr;
  logic [LenW-1:0] fb_wdata;

  eng_state_e      state_q, state_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic [LenW-1:0] bidx_q, bidx_d;
  logic [IdxW-1:0] ml_q, ml_d;
  logic [TiW-1:0]  ti_q, ti_d;
  logic            found_q, found_d;
  logic            ready_q, ready_d;
  logic [IdxW-1:0] t_q, t_d;
  logic [SymW-1:0] sym_q, sym_d;
  logic            last_q, last_d;
  logic [SymW-1:0] prev_q, prev_d;

  logic [LenW-1:0] plen_eff, bidx_eff, bidx_dec, fb_dec, t_inc, jn, t2;
  logic [PosW-1:0] pos_full;
  logic            hit;

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= cmd_i.symbol;
    end
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    if (rd_en) begin
      pat_rd_q <= pat_mem[rd_addr];
      fb_rd_q  <= fb_mem[rd_addr];
    end
  end

  always_comb begin
    plen_eff  = ready_q ? '0 : plen_q;
    bidx_eff  = ready_q ? '0 : bidx_q;
    bidx_dec  = bidx_eff - LenW'(1);
    fb_dec    = fb_rd_q - LenW'(1);
    t_inc     = LenW'(t_q) + LenW'(1);
    jn        = '0;
    t2        = '0;
    pos_full  = '0;
    hit       = 1'b0;

    state_d   = state_q;
    plen_d    = plen_q;
    bidx_d    = bidx_q;
    ml_d      = ml_q;
    ti_d      = ti_q;
    found_d   = found_q;
    ready_d   = ready_q;
    t_d       = t_q;
    sym_d     = sym_q;
    last_d    = last_q;
    prev_d    = prev_q;

    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.status         = ST_TAKEN;
    res_o.match_position = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    pat_we    = 1'b0;
    pat_waddr = plen_eff[IdxW-1:0];
    fb_we     = 1'b0;
    fb_waddr  = '0;
    fb_wdata  = '0;

    case (state_q)
      S_IDLE: begin
        // A command is taken only with room for its result, so the later
        // result write never has to wait.
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          sym_d     = cmd_i.symbol;
          last_d    = cmd_i.last;
          if (cmd_i.op == OP_PATTERN) begin
            ml_d    = '0;
            ti_d    = '0;
            found_d = 1'b0;
            plen_d  = plen_eff;
            bidx_d  = bidx_eff;
            ready_d = 1'b0;
            if (plen_eff >= MaxLen) begin
              res_push_o   = 1'b1;
              res_o.status = ST_ERROR;
              if (cmd_i.last) begin
                plen_d = '0;
                bidx_d = '0;
              end
            end else begin
              pat_we = 1'b1;
              if (plen_eff == '0) begin
                fb_we        = 1'b1;
                fb_waddr     = '0;
                fb_wdata     = '0;
                bidx_d       = '0;
                plen_d       = LenW'(1);
                ready_d      = cmd_i.last;
                prev_d       = cmd_i.symbol;
                res_push_o   = 1'b1;
                res_o.status = ST_TAKEN;
              end else if (bidx_eff == '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                t_d     = '0;
                state_d = S_BUILD_FIN;
              end else begin
                rd_en   = 1'b1;
                rd_addr = bidx_dec[IdxW-1:0];
                t_d     = bidx_dec[IdxW-1:0];
                state_d = S_BUILD_LOOP;
              end
            end
          end else if (!ready_q || plen_q == '0) begin
            res_push_o   = 1'b1;
            res_o.status = ST_ERROR;
          end else if (found_q || ti_q[TextPosBits]) begin
            res_push_o   = 1'b1;
            res_o.status = found_q ? ST_IGNORED : ST_ERROR;
            if (cmd_i.last) begin
              ml_d    = '0;
              ti_d    = '0;
              found_d = 1'b0;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = (LenW'(ml_q) >= plen_q) ? '0 : ml_q;
            t_d     = rd_addr;
            state_d = S_TEXT_CMP;
          end
        end
      end

      S_TEXT_CMP: begin
        hit = (pat_rd_q == sym_q);
        if (hit || fb_rd_q == '0) begin
          jn   = hit ? t_inc : '0;
          ti_d = ti_q + TiW'(1);
          if (jn >= plen_q) begin
            found_d      = 1'b1;
            ml_d         = '0;
            pos_full     = PosW'(ti_q[TextPosBits-1:0]) + PosW'(1) - PosW'(plen_q);
            res_o.status = ST_MATCH;
            res_o.match_position = pos_full[MatchPosW-1:0];
          end else begin
            ml_d         = jn[IdxW-1:0];
            res_o.status = last_q ? ST_NOTFOUND : ST_NOMATCH;
          end
          if (last_q) begin
            ml_d    = '0;
            ti_d    = '0;
            found_d = 1'b0;
          end
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = fb_dec[IdxW-1:0];
          t_d     = fb_dec[IdxW-1:0];
        end
      end

      S_BUILD_LOOP: begin
        hit = (pat_rd_q == prev_q);
        if (hit || fb_rd_q == '0) begin
          t2 = hit ? t_inc : '0;
          if (t2 >= plen_q) begin
            t2 = '0;
          end
          rd_en   = 1'b1;
          rd_addr = t2[IdxW-1:0];
          t_d     = t2[IdxW-1:0];
          state_d = S_BUILD_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = fb_dec[IdxW-1:0];
          t_d     = fb_dec[IdxW-1:0];
        end
      end

      S_BUILD_FIN: begin
        // The optimized entry skips a fallback that would compare the same byte.
        fb_we        = 1'b1;
        fb_waddr     = plen_q[IdxW-1:0];
        fb_wdata     = (sym_q != pat_rd_q) ? t_inc : fb_rd_q;
        bidx_d       = t_inc;
        plen_d       = plen_q + LenW'(1);
        ready_d      = last_q;
        prev_d       = sym_q;
        res_push_o   = 1'b1;
        res_o.status = ST_TAKEN;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plen_q  <= '0;
      bidx_q  <= '0;
      ml_q    <= '0;
      ti_q    <= '0;
      found_q <= 1'b0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      plen_q  <= plen_d;
      bidx_q  <= bidx_d;
      ml_q    <= ml_d;
      ti_q    <= ti_d;
      found_q <= found_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    prev_q <= prev_d;
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written while the result queue is full");

  a_push_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> state_q == S_IDLE)
    else $error("engine busy after delivering a result");

  a_match_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> LenW'(ml_q) < plen_q)
    else $error("match length reached the pattern length");

  a_build_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUILD_LOOP |-> LenW'(t_q) < plen_q)
    else $error("table builder index beyond stored pattern");

  a_found_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ml_q == '0)
    else $error("match length kept after a reported match");

endmodule

[rtl/kmp_substring_search.sv]
// ----------------------------------------------------------------------------
// KMP substring search
// Stores a pattern, builds its optimized fallback table and reports the start
// of the first match in the following text.
// ----------------------------------------------------------------------------
//  channel  | handshake         | fields
//  ---------+-------------------+-------------------------------------
//  input    | push / full       | op_i, symbol_i, last_i
//  result   | pop / empty       | status_o, match_position_o
//
//  Each byte starts in S_IDLE, where refused and ignored bytes and a first
//  pattern byte end. A searched text byte then repeats S_TEXT_CMP per fallback
//  step, as the pattern and fallback memories share a single read port; a later
//  pattern byte repeats S_BUILD_LOOP per fallback step unless the builder index
//  is minus one, then S_BUILD_FIN. Two-entry queues on each side let transfers
//  stall apart. Reset is asynchronous; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module kmp_substring_search #(
  parameter int unsigned MaxPattern  = kmp_pkg::MaxPattern,
  parameter int unsigned TextPosBits = kmp_pkg::TextPosBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            op_i,
  input  logic [kmp_pkg::SymW-1:0]        symbol_i,
  input  logic                            last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [kmp_pkg::StatusW-1:0]     status_o,
  output logic [kmp_pkg::MatchPosW-1:0]   match_position_o
);

  import kmp_pkg::*;

  logic                    cmd_valid;
  cmd_t                    cmd;
  logic                    cmd_pop;
  logic                    res_push;
  res_t                    res_in;
  logic                    res_full;
  logic [$bits(res_t)-1:0] res_head_raw;
  res_t                    res_head;

  kmp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .op_i       (op_i),
    .symbol_i   (symbol_i),
    .last_i     (last_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  kmp_engine #(
    .MaxPattern (MaxPattern),
    .TextPosBits(TextPosBits)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  kmp_fifo #(
    .Width($bits(res_t)),
    .Depth(QueueDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .empty_o(empty),
    .data_o (res_head_raw),
    .pop_i  (pop)
  );

  assign res_head         = res_head_raw;
  assign status_o         = res_head.status;
  assign match_position_o = res_head.match_position;

endmodule
